@@ rtl/core/csd_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN signal decoder package
// Shared types, constants and helpers for the signal decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int SIGNAL_ENTRIES_DEF = 16;
  localparam int ID_W     = 29;
  localparam int LEN_W    = 7;
  localparam int POS_W    = 6;
  localparam int SCALE_W  = 32;
  localparam int OFFSET_W = 48;
  localparam int DATA_W   = 64;
  localparam int SUM_W    = 98;

  localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;
  localparam logic [3:0]       MAX_DLC = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic                       action;
    logic [3:0]                 entry_index;
    logic                       entry_used;
    logic [ID_W-1:0]            message_id;
    logic [POS_W-1:0]           start_bit;
    logic [LEN_W-1:0]           bit_length;
    logic                       little_endian;
    logic                       is_signed;
    logic signed [SCALE_W-1:0]  scale_factor;
    logic signed [OFFSET_W-1:0] offset_value;
    logic [DATA_W-1:0]          frame_data;
    logic [3:0]                 frame_length;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic [3:0]               signal_index;
    logic [LEN_W-1:0]         bits_taken;
    logic [DATA_W-1:0]        raw_value;
    logic signed [DATA_W-1:0] scaled_value;
    logic                     last;
  } out_item_t;

  // Layout of one signal definition.
  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  message_id;
    logic [POS_W-1:0] start_bit;
    logic [LEN_W-1:0] bit_length;
    logic             little_endian;
    logic             is_signed;
  } entry_t;

  // Contents of one ring cell as it moves to its neighbor.
  typedef struct packed {
    entry_t               entry;
    logic [SCALE_W-1:0]   scale;
    logic [OFFSET_W-1:0]  offset;
    logic                 hit;
  } cell_word_t;

  // Extracted value handed to the arithmetic pipeline.
  typedef struct packed {
    logic                found;
    logic [3:0]          index;
    logic [LEN_W-1:0]    taken;
    logic [DATA_W-1:0]   raw;
    logic [DATA_W-1:0]   mag;
    logic                neg;
    logic [SCALE_W-1:0]  scale;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } ext_t;

  // Linear position of the first bit taken. Motorola signals walk a
  // big-endian numbering in which the bit order inside each byte is flipped.
  function automatic logic [POS_W-1:0] first_pos(input entry_t e);
    logic [POS_W-1:0] q;
    if (e.little_endian) begin
      q = e.start_bit;
    end else begin
      q = {e.start_bit[5:3], ~e.start_bit[2:0]};
    end
    return q;
  endfunction

endpackage

@@ rtl/core/csd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Decoder stream interface
// Valid/ready channel that carries one payload per transaction.
// ----------------------------------------------------------------------------
interface csd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/csd_cell.sv @@
// ----------------------------------------------------------------------------
// Signal table ring cell
// Holds one signal definition and passes it to its neighbor on each shift.
// ----------------------------------------------------------------------------
module csd_cell
  import csd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  in_item_t            wr_item,
  input  logic                arm,
  input  logic [ID_W-1:0]     frame_id,
  input  logic [LEN_W-1:0]    dlc8,
  input  logic                shift,
  input  cell_word_t          nxt,
  output cell_word_t          word,
  output logic                hit_now
);

  entry_t              entry;
  logic [SCALE_W-1:0]  scale;
  logic [OFFSET_W-1:0] offset;
  logic                hit;
  entry_t              wr_entry;
  logic [POS_W-1:0]    q;

  // Definition as written, with the length saturated to a full frame.
  always_comb begin
    wr_entry.used          = wr_item.entry_used;
    wr_entry.message_id    = wr_item.message_id;
    wr_entry.start_bit     = wr_item.start_bit;
    wr_entry.bit_length    = (wr_item.bit_length > MAX_LEN) ? MAX_LEN : wr_item.bit_length;
    wr_entry.little_endian = wr_item.little_endian;
    wr_entry.is_signed     = wr_item.is_signed;
  end

  // The entry yields bits for this frame when it matches and starts inside it.
  assign q       = first_pos(entry);
  assign hit_now = entry.used && (entry.message_id == frame_id) && (frame_id != '0) &&
                   (entry.bit_length != '0) && ({1'b0, q} < dlc8);

  // Layout and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      hit   <= 1'b0;
    end else if (shift) begin
      entry <= nxt.entry;
      hit   <= nxt.hit;
    end else if (load) begin
      entry <= wr_entry;
    end else if (arm) begin
      hit <= hit_now;
    end
  end

  // Scale and offset are only read once a write has set them.
  always_ff @(posedge clk) begin
    if (shift) begin
      scale  <= nxt.scale;
      offset <= nxt.offset;
    end else if (load) begin
      scale  <= wr_item.scale_factor;
      offset <= wr_item.offset_value;
    end
  end

  assign word.entry  = entry;
  assign word.scale  = scale;
  assign word.offset = offset;
  assign word.hit    = hit;

endmodule

@@ rtl/core/csd_extract.sv @@
// ----------------------------------------------------------------------------
// Signal bit extractor
// Pulls the signal bits out of the frame and prepares the signed magnitude.
// ----------------------------------------------------------------------------
module csd_extract
  import csd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              load,
  input  logic              not_found,
  input  cell_word_t        head,
  input  logic [3:0]        index,
  input  logic              last,
  input  logic [DATA_W-1:0] data,
  input  logic [LEN_W-1:0]  dlc8,
  output logic              ext_valid,
  output ext_t              ext
);

  logic [POS_W-1:0]  q;
  logic [LEN_W-1:0]  avail;
  logic [LEN_W-1:0]  taken;
  logic [LEN_W-1:0]  mot_amt;
  logic [POS_W-1:0]  sh;
  logic [POS_W-1:0]  top_bit;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] swapped;
  logic [DATA_W-1:0] src;
  logic [DATA_W-1:0] raw;
  logic              neg;
  logic [DATA_W-1:0] mag;
  ext_t              ext_next;

  // Byte swap turns the Motorola walk into a plain right shift.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      swapped[8*b +: 8] = data[8*(7-b) +: 8];
    end
  end

  // Number of bits before the frame's end, and the field alignment.
  always_comb begin
    q       = first_pos(head.entry);
    avail   = dlc8 - {1'b0, q};
    taken   = (head.entry.bit_length < avail) ? head.entry.bit_length : avail;
    mask    = (taken == MAX_LEN) ? '1 : ((64'd1 << taken[5:0]) - 64'd1);
    mot_amt = MAX_LEN - {1'b0, q} - taken;
    sh      = head.entry.little_endian ? q : mot_amt[POS_W-1:0];
    src     = head.entry.little_endian ? data : swapped;
    raw     = (src >> sh) & mask;
    top_bit = taken[POS_W-1:0] - 6'd1;
    neg     = head.entry.is_signed && (taken != MAX_LEN) && raw[top_bit];
    mag     = neg ? (64'd0 - (raw | ~mask)) : raw;
  end

  // Result of this step, or the empty no-match record.
  always_comb begin
    if (not_found) begin
      ext_next      = '0;
      ext_next.last = 1'b1;
    end else begin
      ext_next.found  = 1'b1;
      ext_next.index  = index;
      ext_next.taken  = taken;
      ext_next.raw    = raw;
      ext_next.mag    = mag;
      ext_next.neg    = neg;
      ext_next.scale  = head.scale;
      ext_next.offset = head.offset;
      ext_next.last   = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_valid <= 1'b0;
    end else if (adv) begin
      ext_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ext <= ext_next;
    end
  end

endmodule

@@ rtl/core/csd_scale.sv @@
// ----------------------------------------------------------------------------
// Signal scaling pipeline
// Multiplies by the scale, adds the offset and saturates to 64 bits.
// ----------------------------------------------------------------------------
module csd_scale
  import csd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      ext_valid,
  input  ext_t      ext,
  input  logic      out_ready,
  output logic      adv,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  // Multiply stage registers.
  logic                s2_valid;
  ext_t                s2;
  logic                s2_neg;
  logic [63:0]         s2_p0;
  logic [63:0]         s2_p1;
  // Sum stage registers.
  logic                s3_valid;
  ext_t                s3;
  logic signed [SUM_W-1:0] s3_sum;

  logic                sneg;
  logic [SCALE_W-1:0]  smag;
  logic [95:0]         prod;
  logic signed [SUM_W-1:0] sval;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [63:0]  sat;

  assign adv = !out_valid || out_ready;

  // Two 32 by 32 partial products of the magnitude.
  assign sneg = ext.scale[SCALE_W-1];
  assign smag = sneg ? (32'd0 - ext.scale) : ext.scale;

  // Combine the partial products, apply the sign and add the offset.
  always_comb begin
    prod     = {32'd0, s2_p0} + {s2_p1, 32'd0};
    sval     = s2_neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    sum_next = sval + SUM_W'($signed(s2.offset));
  end

  // Saturate to the signed 64-bit range.
  always_comb begin
    if (s3_sum > SAT_MAX) begin
      sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (s3_sum < SAT_MIN) begin
      sat = $signed(64'h8000_0000_0000_0000);
    end else begin
      sat = s3_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= ext_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2     <= ext;
      s2_neg <= ext.neg ^ sneg;
      s2_p0  <= ext.mag[31:0] * smag;
      s2_p1  <= ext.mag[63:32] * smag;
      s3     <= s2;
      s3_sum <= sum_next;
      out_item.found        <= s3.found;
      out_item.signal_index <= s3.index;
      out_item.bits_taken   <= s3.taken;
      out_item.raw_value    <= s3.raw;
      out_item.scaled_value <= s3.found ? sat : '0;
      out_item.last         <= s3.last;
    end
  end

endmodule

@@ rtl/core/can_signal_decoder.sv @@
// ----------------------------------------------------------------------------
// CAN signal decoder
// Signal definition table and frame decoder with fixed point scaling.
// ----------------------------------------------------------------------------
// A write transaction stores one signal definition. A decode transaction
// marks every matching entry at once, then rotates the table ring one cell
// per cycle past a single extractor while the output is not stalled. The
// input stays busy until every entry has passed the head, and a frame that
// matches nothing is done as soon as it is taken. Each result leaves the
// extractor and passes the multiply, sum and output registers; a stalled
// output holds the whole ring and pipeline.
module can_signal_decoder
  import csd_pkg::*;
#(
  parameter int SIGNAL_ENTRIES = SIGNAL_ENTRIES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  csd_stream_if.sink   in_stream,
  csd_stream_if.source out_stream
);

  localparam int IDX_W = (SIGNAL_ENTRIES > 1) ? $clog2(SIGNAL_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIGNAL_ENTRIES - 1);

  state_t                   state;
  logic [IDX_W-1:0]         cnt;
  logic [DATA_W-1:0]        frame_data;
  logic [LEN_W-1:0]         frame_dlc8;
  logic [LEN_W-1:0]         in_dlc8;
  logic [3:0]               in_dlc;
  in_item_t                 item;
  logic                     adv;
  logic                     accept;
  logic                     wr;
  logic                     dec;
  logic                     rotate;
  logic                     any_hit_now;
  logic                     others_hit;
  logic [SIGNAL_ENTRIES-1:0] load_vec;
  logic [SIGNAL_ENTRIES-1:0] hit_now_vec;
  logic [SIGNAL_ENTRIES-1:0] hit_vec;
  cell_word_t               words [SIGNAL_ENTRIES];
  cell_word_t               ring_in [SIGNAL_ENTRIES];
  logic                     ext_valid;
  ext_t                     ext;
  logic                     ext_load;
  logic                     not_found;
  logic                     out_valid;
  out_item_t                out_item;

  assign item   = in_stream.data;
  assign accept = in_stream.valid && in_stream.ready;
  assign wr     = accept && !item.action;
  assign dec    = accept && item.action;
  assign rotate = (state == ST_RUN) && adv;

  assign in_stream.ready = (state == ST_IDLE) && adv;

  // Frame length in bits, capped at eight bytes.
  assign in_dlc  = (item.frame_length > MAX_DLC) ? MAX_DLC : item.frame_length;
  assign in_dlc8 = {in_dlc, 3'b000};

  // Per-entry write enables; indexes beyond the table are dropped.
  always_comb begin
    for (int k = 0; k < SIGNAL_ENTRIES; k++) begin
      load_vec[k] = wr && (int'(item.entry_index) == k);
    end
  end

  // Ring of cells: each cell takes its upper neighbor's word, and the head
  // re-enters at the tail with its match flag cleared.
  for (genvar k = 0; k < SIGNAL_ENTRIES; k++) begin : g_ring
    always_comb begin
      ring_in[k] = words[(k + 1) % SIGNAL_ENTRIES];
      if (k == SIGNAL_ENTRIES - 1) begin
        ring_in[k].hit = 1'b0;
      end
    end

    csd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (load_vec[k]),
      .wr_item  (item),
      .arm      (dec),
      .frame_id (item.message_id),
      .dlc8     (in_dlc8),
      .shift    (rotate),
      .nxt      (ring_in[k]),
      .word     (words[k]),
      .hit_now  (hit_now_vec[k])
    );

    assign hit_vec[k] = words[k].hit;
  end

  assign any_hit_now = |hit_now_vec;
  assign others_hit  = |(hit_vec & ~SIGNAL_ENTRIES'(1));

  // Sequencer: one rotation per cycle unless stalled, until all have passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (dec && any_hit_now) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (cnt == LAST_IDX) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Frame held for the extractor during the walk.
  always_ff @(posedge clk) begin
    if (dec) begin
      frame_data <= item.frame_data;
      frame_dlc8 <= in_dlc8;
    end
  end

  assign not_found = (state == ST_IDLE) && dec && !any_hit_now;
  assign ext_load  = not_found || ((state == ST_RUN) && hit_vec[0]);

  csd_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .load      (ext_load),
    .not_found (not_found),
    .head      (words[0]),
    .index     (4'(cnt)),
    .last      (!others_hit),
    .data      (frame_data),
    .dlc8      (frame_dlc8),
    .ext_valid (ext_valid),
    .ext       (ext)
  );

  csd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .ext_valid (ext_valid),
    .ext       (ext),
    .out_ready (out_stream.ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_stream.valid = out_valid;
  assign out_stream.data  = out_item;

endmodule
